// ===== design/delay_line_pitch_shifter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pitch shifter
// Clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DELAY_LINE_PITCH_SHIFTER_UNIT_MACROS_SVH
`define DELAY_LINE_PITCH_SHIFTER_UNIT_MACROS_SVH

// same-cycle implication
`define DLPS_ASSERT_SAME(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLPS_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared constants and types of the delay line pitch shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlps_pkg;

   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_W     = 19;
   localparam int CSR_IDX_W = 2;
   localparam int PITCH_W   = 19;
   localparam int RATIO_W   = 14;
   localparam int RATE_W    = 18;
   localparam int PH_W      = 21;
   localparam int FADE_W    = 17;

   localparam int DIV_NW = 32;
   localparam int DIV_DW = 20;

   localparam logic [PITCH_W-1:0] MIN_PITCH_RST   = PITCH_W'(800);
   localparam logic [PITCH_W-1:0] MAX_PITCH_RST   = PITCH_W'(256000);
   localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(44100);
   localparam int WINDOW_RST = 76800;

   localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PITCH   = 2'd0,
      CSR_MAX_PITCH   = 2'd1,
      CSR_SAMPLE_RATE = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

endpackage

`default_nettype wire

// ===== design/dlps_mem.sv =====
// ----------------------------------------------------------------------------
// dlps_mem
// Delay line storage: one write port, one registered read port. Slots not
// yet written since reset read as zero (tracked by a fill count).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "delay_line_pitch_shifter_unit_macros.svh"

module dlps_mem #(
   parameter int DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DELAY_DEPTH)-1:0] wr_addr,
   input  wire logic [SAMPLE_BITS-1:0]         wr_data,
   input  wire logic [$clog2(DELAY_DEPTH)-1:0] rd_addr,
   output logic      [SAMPLE_BITS-1:0]         rd_data
);

   localparam int AW = $clog2(DELAY_DEPTH);

   logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic                   rd_vld_ff;
   logic [AW:0]            fill_ff;
   logic [AW:0]            fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (wr_en && (fill_ff != (AW+1)'(DELAY_DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff     <= mem[rd_addr];
      rd_vld_ff <= ({1'b0, rd_addr} < fill_ff);
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

   `DLPS_ASSERT_SAME(a_fill_limit, 1'b1, fill_ff <= (AW+1)'(DELAY_DEPTH), "fill count past depth")
   `DLPS_ASSERT_NEXT(a_fill_grow, wr_en && (fill_ff < (AW+1)'(DELAY_DEPTH)), fill_ff == $past(fill_ff) + 1'b1, "fill count missed a write")

endmodule

`default_nettype wire

// ===== design/dlps_div.sv =====
// ----------------------------------------------------------------------------
// dlps_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlps_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dlps_pkg::div_req_type       div_req,
   output logic                             busy,
   output logic                             done,
   output logic [dlps_pkg::DIV_NW-1:0]      quo
);

   localparam int NW = dlps_pkg::DIV_NW;
   localparam int DW = dlps_pkg::DIV_DW;
   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   shifted;
   logic [DW+1:0] diff;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      if (busy_ff) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ===== design/delay_line_pitch_shifter_unit.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter_unit
// Delay line pitch shifter with crossfade, one shared multiplier and one
// serial divider under a step sequencer.
// ----------------------------------------------------------------------------
// One item at a time: after an item is accepted req_ready stays low until the
// sequencer is back in idle, which takes longer with a crossfade or a window
// update, and also while a finished item waits for rsp_ready. The time goes to
// the single multiplier, which forms the cubic weights, tap products, the
// reciprocal products for the fade level and the interpolation scaling, and the
// sine fade curves one product per cycle, and to the serial divider for the
// window update. A read that lands on a whole sample skips the weights and is
// shorter. A finished item waits in the rsp register. DELAY_DEPTH must be a
// power of two. No clearing pass: unwritten slots read as zero.
`timescale 1ns / 1ps
`default_nettype none
`include "delay_line_pitch_shifter_unit_macros.svh"

module delay_line_pitch_shifter_unit #(
   parameter int DELAY_DEPTH = dlps_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_in_sample,
   input  wire logic [dlps_pkg::RATIO_W-1:0]        req_pitch_ratio,
   input  wire logic [dlps_pkg::PITCH_W-1:0]        req_detected_pitch,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]            rsp_out_sample,
   input  wire logic                                csr_we,
   input  wire logic [dlps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dlps_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int AW      = $clog2(DELAY_DEPTH);
   localparam int PH_W    = dlps_pkg::PH_W;
   localparam int FW      = dlps_pkg::FADE_W;
   localparam int WIN_MAX = (DELAY_DEPTH - 8) * 256;
   localparam int WIN_W   = $clog2(WIN_MAX + 1);
   localparam int POS_W   = ((WIN_W > PH_W) ? WIN_W : PH_W) + 3;
   localparam int ACC_W   = SAMPLE_BITS + 34;
   localparam int SMP_W   = SAMPLE_BITS + 3;
   localparam int RES_W   = SAMPLE_BITS + 5;
   localparam int NW      = dlps_pkg::DIV_NW;

   // floor(x/60) and floor(x/6) as multiply and shift, exact over the used range
   localparam logic signed [31:0] FADE_RCP   = 32'sd4473925;
   localparam int                 FADE_SH    = 28;
   localparam logic signed [31:0] INTERP_RCP = 32'sd715827883;
   localparam int                 INTERP_SH  = 32;

   localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_PH   = 12'b000000000010,
      ST_FADE = 12'b000000000100,
      ST_FDIV = 12'b000000001000,
      ST_POS  = 12'b000000010000,
      ST_WGT  = 12'b000000100000,
      ST_TAP  = 12'b000001000000,
      ST_IDIV = 12'b000010000000,
      ST_SINE = 12'b000100000000,
      ST_MIX  = 12'b001000000000,
      ST_WIN  = 12'b010000000000,
      ST_WDIV = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] stp_ff, stp_in;
   logic       half_ff, half_in;
   logic       tap_sel_ff, tap_sel_in;
   logic       direct_ff, direct_in;

   logic [dlps_pkg::RATIO_W-1:0] ratio_ff, ratio_in;
   logic [dlps_pkg::PITCH_W-1:0] pitch_ff, pitch_in;
   logic [dlps_pkg::PITCH_W-1:0] min_pitch_ff, min_pitch_in;
   logic [dlps_pkg::PITCH_W-1:0] max_pitch_ff, max_pitch_in;
   logic [dlps_pkg::RATE_W-1:0]  sample_rate_ff, sample_rate_in;

   logic [AW-1:0]           wp_ff, wp_in;
   logic signed [PH_W-1:0]  ph_ff, ph_in;
   logic [WIN_W-1:0]        win_ff, win_in;
   logic [FW-1:0]           fade_ff, fade_in;

   logic [AW-1:0]           n_ff, n_in;
   logic [7:0]              t_ff, t_in;
   logic signed [31:0]      rs_ff, rs_in;
   logic signed [31:0]      pq_ff, pq_in;
   logic signed [31:0]      w_ff [4];
   logic signed [31:0]      w_in [4];
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [SMP_W-1:0] samp_ff, samp_in;
   logic signed [SMP_W-1:0] fs_ff, fs_in;
   logic signed [31:0]      x2_ff, x2_in;
   logic [FW-1:0]           sc_ff, sc_in;
   logic [FW-1:0]           ss_ff, ss_in;
   logic signed [63:0]      pa_ff, pa_in;
   logic signed [RES_W-1:0] res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic signed [31:0]      mul_a, mul_b;
   logic signed [63:0]      mul_p_ff;
   logic signed [31:0]      p_hi;

   dlps_pkg::div_req_type   div_req;
   logic                    div_busy, div_done;
   logic [NW-1:0]           div_quo;

   logic                    mem_we;
   logic [AW-1:0]           mem_rd_addr;
   logic [SAMPLE_BITS-1:0]  mem_rd_data;

   logic signed [15:0]      step_q8;
   logic signed [POS_W-1:0] ph_sum, ph_adj, winx, pos;
   logic signed [31:0]      ph_ext, fade_num;
   logic signed [31:0]      wq, wp_s, wr_s, ws_s;
   logic [AW-1:0]           tap_off;
   logic [1:0]              widx;
   logic signed [ACC_W-1:0] acc_shr;
   logic                    interp_fin;
   logic signed [SMP_W-1:0] interp_val;
   logic signed [31:0]      sine_x, sine_r;
   logic [FW:0]             wa_sum, wb_sum;
   logic signed [63:0]      mix_sum;
   logic [NW:0]             nw, negph;

   assign req_ready = (state_ff == ST_IDLE);
   assign mem_we    = req_valid && req_ready;
   assign p_hi      = mul_p_ff[47:16];

   dlps_mem #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data (req_in_sample),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dlps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .busy    (div_busy),
      .done    (div_done),
      .quo     (div_quo)
   );

   // datapath helpers
   always_comb begin
      step_q8  = 16'(($signed({2'b00, ratio_ff}) - 16'sd4088) >>> 4);
      winx     = $signed(POS_W'(win_ff));
      ph_sum   = POS_W'(ph_ff) + POS_W'(step_q8);
      ph_adj   = ph_sum;
      if (ph_sum > 0) begin
         ph_adj = ph_sum - winx;
      end else if (ph_sum < -winx) begin
         ph_adj = ph_sum + winx;
      end
      ph_ext   = 32'(ph_ff);
      fade_num = (ph_ext <<< 9) + 32'sd3932190;
      pos      = POS_W'(ph_ff) - (tap_sel_ff ? winx : POS_W'(0)) - POS_W'(1280);
      wq       = 32'(t_ff);
      wp_s     = 32'(t_ff) + 32'sd256;
      wr_s     = 32'(t_ff) - 32'sd256;
      ws_s     = 32'(t_ff) - 32'sd512;
      tap_off  = direct_ff ? AW'(0) : (AW'(stp_ff) - AW'(1));
      widx     = 2'(stp_ff - 3'd1);
      acc_shr  = (acc_ff + ACC_W'(50331648)) >>> 24;
      sine_x   = half_ff ? 32'(fade_ff) : (32'sd65536 - 32'(fade_ff));
      sine_r   = p_hi;
      if (sine_r < 0) begin
         sine_r = 32'sd0;
      end else if (sine_r > 32'sd65536) begin
         sine_r = 32'sd65536;
      end
      wa_sum   = ({1'b0, sc_ff} + (FW+1)'(65536) - {1'b0, fade_ff}) >> 1;
      wb_sum   = ({1'b0, ss_ff} + {1'b0, fade_ff}) >> 1;
      mix_sum  = pa_ff + mul_p_ff + 64'sd32768;
      negph    = (NW+1)'(-ph_ext);
      nw       = {1'b0, div_quo};
      if (nw < negph) begin
         nw = negph;
      end
      if (nw > (NW+1)'(WIN_MAX)) begin
         nw = (NW+1)'(WIN_MAX);
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      stp_in         = stp_ff;
      half_in        = half_ff;
      tap_sel_in     = tap_sel_ff;
      direct_in      = direct_ff;
      ratio_in       = ratio_ff;
      pitch_in       = pitch_ff;
      min_pitch_in   = min_pitch_ff;
      max_pitch_in   = max_pitch_ff;
      sample_rate_in = sample_rate_ff;
      wp_in          = wp_ff;
      ph_in          = ph_ff;
      win_in         = win_ff;
      fade_in        = fade_ff;
      n_in           = n_ff;
      t_in           = t_ff;
      rs_in          = rs_ff;
      pq_in          = pq_ff;
      w_in           = w_ff;
      acc_in         = acc_ff;
      samp_in        = samp_ff;
      fs_in          = fs_ff;
      x2_in          = x2_ff;
      sc_in          = sc_ff;
      ss_in          = ss_ff;
      pa_in          = pa_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      mul_a          = '0;
      mul_b          = '0;
      div_req        = '0;
      mem_rd_addr    = wp_ff + n_ff + tap_off;
      interp_fin     = 1'b0;
      interp_val     = '0;

      if (csr_we) begin
         unique case (csr_index)
            dlps_pkg::CSR_MIN_PITCH:   min_pitch_in   = csr_wdata;
            dlps_pkg::CSR_MAX_PITCH:   max_pitch_in   = csr_wdata;
            dlps_pkg::CSR_SAMPLE_RATE: sample_rate_in = csr_wdata[dlps_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ratio_in = req_pitch_ratio;
               pitch_in = req_detected_pitch;
               wp_in    = wp_ff + 1'b1;
               state_in = ST_PH;
            end
         end
         ST_PH: begin
            if (ph_adj > POS_W'(1048575)) begin
               ph_in = PH_W'(1048575);
            end else if (ph_adj < -POS_W'(1048576)) begin
               ph_in = PH_W'(-1048576);
            end else begin
               ph_in = ph_adj[PH_W-1:0];
            end
            state_in = ST_FADE;
         end
         ST_FADE: begin
            tap_sel_in = 1'b0;
            if (!ph_ff[PH_W-1]) begin
               fade_in  = dlps_pkg::FADE_ONE;
               state_in = ST_POS;
            end else if (ph_ff < -PH_W'(7680)) begin
               fade_in  = '0;
               state_in = ST_POS;
            end else begin
               mul_a    = fade_num;
               mul_b    = FADE_RCP;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            fade_in  = mul_p_ff[FADE_SH+FW-1:FADE_SH];
            state_in = ST_POS;
         end
         ST_POS: begin
            n_in      = pos[AW+7:8];
            t_in      = pos[7:0];
            stp_in    = '0;
            acc_in    = '0;
            direct_in = (pos[7:0] == 8'd0);
            state_in  = (pos[7:0] == 8'd0) ? ST_TAP : ST_WGT;
         end
         ST_WGT: begin
            stp_in = stp_ff + 1'b1;
            case (stp_ff)
               3'd0: begin
                  mul_a = wr_s;
                  mul_b = ws_s;
               end
               3'd1: begin
                  rs_in = mul_p_ff[31:0];
                  mul_a = wq;
                  mul_b = mul_p_ff[31:0];
               end
               3'd2: begin
                  w_in[0] = -mul_p_ff[31:0];
                  mul_a   = wp_s;
                  mul_b   = rs_ff;
               end
               3'd3: begin
                  w_in[1] = 32'(mul_p_ff[31:0] * 32'sd3);
                  mul_a   = wp_s;
                  mul_b   = wq;
               end
               3'd4: begin
                  pq_in = mul_p_ff[31:0];
                  mul_a = mul_p_ff[31:0];
                  mul_b = ws_s;
               end
               3'd5: begin
                  w_in[2] = 32'(mul_p_ff[31:0] * -32'sd3);
                  mul_a   = pq_ff;
                  mul_b   = wr_s;
               end
               default: begin
                  w_in[3] = mul_p_ff[31:0];
                  stp_in  = '0;
                  state_in = ST_TAP;
               end
            endcase
         end
         ST_TAP: begin
            stp_in = stp_ff + 1'b1;
            if (direct_ff) begin
               if (stp_ff != 3'd0) begin
                  interp_fin = 1'b1;
                  interp_val = SMP_W'($signed(mem_rd_data));
               end
            end else begin
               if ((stp_ff >= 3'd1) && (stp_ff <= 3'd4)) begin
                  mul_a = 32'($signed(mem_rd_data));
                  mul_b = w_ff[widx];
               end
               if (stp_ff >= 3'd2) begin
                  acc_in = acc_ff + mul_p_ff[ACC_W-1:0];
               end
               if (stp_ff == 3'd5) begin
                  stp_in   = '0;
                  state_in = ST_IDIV;
               end
            end
         end
         ST_IDIV: begin
            if (stp_ff == 3'd0) begin
               mul_a  = 32'(acc_shr + ACC_W'(6 << SAMPLE_BITS));
               mul_b  = INTERP_RCP;
               stp_in = 3'd1;
            end else begin
               interp_fin = 1'b1;
               interp_val = $signed({1'b0, mul_p_ff[INTERP_SH+SMP_W-2:INTERP_SH]})
                            - SMP_W'(1 << SAMPLE_BITS);
            end
         end
         ST_SINE: begin
            stp_in = stp_ff + 1'b1;
            case (stp_ff)
               3'd0: begin
                  mul_a = sine_x;
                  mul_b = sine_x;
               end
               3'd1: begin
                  x2_in = p_hi;
                  mul_a = p_hi;
                  mul_b = 32'sd307;
               end
               3'd2: begin
                  mul_a = x2_ff;
                  mul_b = 32'sd5223 - p_hi;
               end
               3'd3: begin
                  mul_a = x2_ff;
                  mul_b = 32'sd42334 - p_hi;
               end
               3'd4: begin
                  mul_a = sine_x;
                  mul_b = 32'sd102944 - p_hi;
               end
               default: begin
                  stp_in = '0;
                  if (!half_ff) begin
                     sc_in   = sine_r[FW-1:0];
                     half_in = 1'b1;
                  end else begin
                     ss_in    = sine_r[FW-1:0];
                     state_in = ST_MIX;
                  end
               end
            endcase
         end
         ST_MIX: begin
            stp_in = stp_ff + 1'b1;
            case (stp_ff)
               3'd0: begin
                  if (fade_ff == '0) begin
                     res_in = RES_W'(samp_ff);
                     stp_in = 3'd3;
                  end else begin
                     mul_a = 32'(samp_ff);
                     mul_b = 32'(wa_sum);
                  end
               end
               3'd1: begin
                  pa_in = mul_p_ff;
                  mul_a = 32'(fs_ff);
                  mul_b = 32'(wb_sum);
               end
               3'd2: begin
                  res_in = mix_sum[RES_W+15:16];
               end
               default: begin
                  stp_in = stp_ff;
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in = 1'b1;
                     if (res_ff > SAT_HI) begin
                        rsp_sample_in = SAT_HI[SAMPLE_BITS-1:0];
                     end else if (res_ff < SAT_LO) begin
                        rsp_sample_in = SAT_LO[SAMPLE_BITS-1:0];
                     end else begin
                        rsp_sample_in = res_ff[SAMPLE_BITS-1:0];
                     end
                     state_in = ST_WIN;
                  end
               end
            endcase
         end
         ST_WIN: begin
            if ((fade_ff == '0) && (pitch_ff > min_pitch_ff) && (pitch_ff < max_pitch_ff)
                && (pitch_ff != '0)) begin
               div_req.start = 1'b1;
               div_req.num   = {1'b0, sample_rate_ff, 13'd0} + NW'(pitch_ff);
               div_req.den   = {pitch_ff, 1'b0};
               state_in      = ST_WDIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WDIV: begin
            if (div_done) begin
               win_in   = nw[WIN_W-1:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (interp_fin) begin
         stp_in = '0;
         if (!tap_sel_ff) begin
            samp_in = interp_val;
            if (fade_ff != '0) begin
               tap_sel_in = 1'b1;
               state_in   = ST_POS;
            end else begin
               state_in = ST_MIX;
            end
         end else begin
            fs_in    = interp_val;
            half_in  = 1'b0;
            state_in = ST_SINE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stp_ff         <= '0;
         half_ff        <= 1'b0;
         tap_sel_ff     <= 1'b0;
         direct_ff      <= 1'b0;
         min_pitch_ff   <= dlps_pkg::MIN_PITCH_RST;
         max_pitch_ff   <= dlps_pkg::MAX_PITCH_RST;
         sample_rate_ff <= dlps_pkg::SAMPLE_RATE_RST;
         wp_ff          <= '0;
         ph_ff          <= '0;
         win_ff         <= WIN_W'(dlps_pkg::WINDOW_RST);
         fade_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stp_ff         <= stp_in;
         half_ff        <= half_in;
         tap_sel_ff     <= tap_sel_in;
         direct_ff      <= direct_in;
         min_pitch_ff   <= min_pitch_in;
         max_pitch_ff   <= max_pitch_in;
         sample_rate_ff <= sample_rate_in;
         wp_ff          <= wp_in;
         ph_ff          <= ph_in;
         win_ff         <= win_in;
         fade_ff        <= fade_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      ratio_ff      <= ratio_in;
      pitch_ff      <= pitch_in;
      n_ff          <= n_in;
      t_ff          <= t_in;
      rs_ff         <= rs_in;
      pq_ff         <= pq_in;
      w_ff          <= w_in;
      acc_ff        <= acc_in;
      samp_ff       <= samp_in;
      fs_ff         <= fs_in;
      x2_ff         <= x2_in;
      sc_ff         <= sc_in;
      ss_ff         <= ss_in;
      pa_ff         <= pa_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      mul_p_ff      <= mul_a * mul_b;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;

   `DLPS_ASSERT_NEXT(a_accept_to_ph, req_valid && req_ready, state_ff == ST_PH, "accepted item did not start the sequence")
   `DLPS_ASSERT_SAME(a_div_free, div_req.start, !div_busy, "divider started while busy")
   `DLPS_ASSERT_SAME(a_win_limit, 1'b1, win_ff <= WIN_W'(WIN_MAX), "window past its limit")
   `DLPS_ASSERT_SAME(a_fade_limit, 1'b1, fade_ff <= dlps_pkg::FADE_ONE, "fade level past unity")

endmodule

`default_nettype wire

// ===== dv/delay_line_pitch_shifter_unit_test.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter_unit_test
// Self-checking bench for the pitch shifter. A built-in model of the delay
// line, playhead, crossfade and window update predicts each output sample.
// Directed corner items come first, then random phases under several
// register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delay_line_pitch_shifter_unit_test;
   import dlps_pkg::*;

   localparam int DEPTH = 4096;
   localparam int SB = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint WIN_CAP = longint'(DEPTH - 8) * 256;
   localparam longint PH_HI = 1048575;
   localparam longint PH_LO = -1048576;

   typedef struct {
      logic signed [SB-1:0]  in_sample;
      logic [RATIO_W-1:0]    pitch_ratio;
      logic [PITCH_W-1:0]    detected_pitch;
   } audio_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SB-1:0] req_in_sample = '0;
   logic [RATIO_W-1:0] req_pitch_ratio = '0;
   logic [PITCH_W-1:0] req_detected_pitch = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_out_sample;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   delay_line_pitch_shifter_unit dut (.*);

   audio_item_t pending_items[$];
   logic signed [SB-1:0] expected_samples[$];
   int send_idle = 30;
   int recv_idle = 88;
   int errors = 0;
   int checked = 0;

   // shadow state
   longint line_mem[DEPTH];
   longint wr_ptr, head_pos, win_q8;
   longint lo_pitch, hi_pitch, rate_hz;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12_000_000);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint rdiv(longint a, longint b);
      return fdiv(2 * a + b, 2 * b);
   endfunction

   function automatic longint line_tap(longint k);
      longint r;
      r = (wr_ptr + k) % DEPTH;
      if (r < 0) r += DEPTH;
      return line_mem[r];
   endfunction

   function automatic longint cubic_read(longint pos);
      longint n, t, a0, a1, a2, a3, acc;
      n = fdiv(pos, 256);
      t = pos - n * 256;
      if (t == 0) return line_tap(n);
      a0 = -t * (t - 256) * (t - 512);
      a1 = 3 * (t + 256) * (t - 256) * (t - 512);
      a2 = -3 * (t + 256) * t * (t - 512);
      a3 = (t + 256) * t * (t - 256);
      acc = line_tap(n - 1) * a0 + line_tap(n) * a1 + line_tap(n + 1) * a2
            + line_tap(n + 2) * a3;
      return rdiv(acc, 64'd6 * 16777216);
   endfunction

   function automatic longint sine_curve(longint x);
      longint x2, t, r;
      x2 = (x * x) >>> 16;
      t = 5223 - ((x2 * 307) >>> 16);
      t = 42334 - ((x2 * t) >>> 16);
      t = 102944 - ((x2 * t) >>> 16);
      r = (x * t) >>> 16;
      if (r < 0) r = 0;
      if (r > 65536) r = 65536;
      return r;
   endfunction

   function automatic logic signed [SB-1:0] shift_sample(audio_item_t it);
      longint ph, fade, samp, res, fs, wa, wb, nw, win, pitch;
      win = win_q8;
      pitch = it.detected_pitch;
      line_mem[wr_ptr] = longint'(it.in_sample);
      wr_ptr = (wr_ptr + 1) % DEPTH;
      ph = head_pos + fdiv(longint'(it.pitch_ratio) - 4096 + 8, 16);
      if (ph > 0) ph -= win;
      else if (ph < -win) ph += win;
      if (ph > PH_HI) ph = PH_HI;
      if (ph < PH_LO) ph = PH_LO;
      head_pos = ph;
      fade = 65536 + rdiv(ph * 256, 30);
      if (fade < 0) fade = 0;
      if (fade > 65536) fade = 65536;
      samp = cubic_read(ph - 1280);
      if (fade > 0) begin
         fs = cubic_read(ph - win - 1280);
         wa = (sine_curve(65536 - fade) + 65536 - fade) >>> 1;
         wb = (sine_curve(fade) + fade) >>> 1;
         res = rdiv(samp * wa + fs * wb, 65536);
      end else begin
         res = samp;
      end
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      if (fade == 0 && pitch > lo_pitch && pitch < hi_pitch && pitch != 0) begin
         nw = rdiv(rate_hz * 4096, pitch);
         if (nw < -ph) nw = -ph;
         if (nw > WIN_CAP) nw = WIN_CAP;
         if (nw < 0) nw = 0;
         win_q8 = nw;
      end
      return SB'(res);
   endfunction

   // driver
   always @(posedge clock) begin
      audio_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            it.in_sample = req_in_sample;
            it.pitch_ratio = req_pitch_ratio;
            it.detected_pitch = req_detected_pitch;
            expected_samples.push_back(shift_sample(it));
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_in_sample <= it.in_sample;
               req_pitch_ratio <= it.pitch_ratio;
               req_detected_pitch <= it.detected_pitch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [SB-1:0] exp_s;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected item: out_sample %0d", rsp_out_sample);
               errors++;
            end else begin
               exp_s = expected_samples.pop_front();
               checked++;
               if (rsp_out_sample !== exp_s) begin
                  $error("out_sample: expected %0d, actual %0d", exp_s, rsp_out_sample);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_PITCH:   lo_pitch = val;
         CSR_MAX_PITCH:   hi_pitch = val;
         CSR_SAMPLE_RATE: rate_hz = val[RATE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_item(int s, int r, int p);
      audio_item_t it;
      it.in_sample = SB'(s);
      it.pitch_ratio = RATIO_W'(r);
      it.detected_pitch = PITCH_W'(p);
      pending_items.push_back(it);
   endtask

   task automatic drain;
      while (pending_items.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int s, r, p;
      repeat (count) begin
         s = $urandom_range(7) == 0 ? ($urandom_range(1) ? 32767 : -32768)
                                    : int'($urandom_range(65535)) - 32768;
         case ($urandom_range(9))
            0, 1:    r = $urandom_range(16383);
            2:       r = 4096;
            default: r = $urandom_range(6144, 2048);
         endcase
         case ($urandom_range(3))
            0:       p = $urandom_range(524287);
            1:       p = $urandom_range(1000, 40000);
            2:       p = $urandom_range(200000, 524287);
            default: p = $urandom_range(lo_pitch + 1, lo_pitch + 20000);
         endcase
         add_item(s, r, p);
      end
   endtask

   initial begin
      foreach (line_mem[i]) line_mem[i] = 0;
      wr_ptr = 0;
      head_pos = 0;
      win_q8 = WINDOW_RST;
      lo_pitch = MIN_PITCH_RST;
      hi_pitch = MAX_PITCH_RST;
      rate_hz = SAMPLE_RATE_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, unity, deep playhead for window updates, pitch zero
      add_item(32767, 4096, 3520);
      add_item(-32768, 16383, 524287);
      add_item(0, 0, 0);
      add_item(12345, 4097, 1);
      add_item(-1, 4095, 800);
      add_item(32767, 8, 256000);
      repeat (8) add_item(int'($urandom_range(65535)) - 32768, 0, 3520);
      add_item(-32768, 0, 52000);
      add_item(32767, 0, 255999);
      add_item(100, 16383, 801);
      add_item(-200, 16383, 3520);
      add_item(32767, 2048, 0);
      add_item(-32768, 6144, 524287);
      drain();

      // wide open bounds, high sample rate, tiny windows possible
      csr_write(CSR_MIN_PITCH, 0);
      csr_write(CSR_MAX_PITCH, 19'h7FFFF);
      csr_write(CSR_SAMPLE_RATE, 192000);
      csr_write(CSR_SPARE, $urandom_range(524287));
      random_phase(310);
      drain();

      send_idle = 88;
      recv_idle = 30;
      csr_write(CSR_MIN_PITCH, 100);
      csr_write(CSR_MAX_PITCH, 300000);
      csr_write(CSR_SAMPLE_RATE, 8000);
      random_phase(310);
      drain();

      send_idle = 0;
      recv_idle = 0;
      csr_write(CSR_MIN_PITCH, 2000);
      csr_write(CSR_MAX_PITCH, 0);
      csr_write(CSR_SAMPLE_RATE, 19'h7FFFF);
      random_phase(60);
      drain();
      csr_write(CSR_MIN_PITCH, 0);
      csr_write(CSR_MAX_PITCH, 524287);
      csr_write(CSR_SAMPLE_RATE, 262143);
      random_phase(250);
      drain();

      $display("Checked %0d output samples over four register settings", checked);
      $display("and three handshake idling patterns, plus directed corners.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
